// ===== hdl/lcdn_pkg.sv =====
// Shared types, constants and the strobe table for the 4-bit character LCD sequencer.
// Used by every module of the block; depends on nothing.
package lcdn_pkg;

  localparam logic [1:0] OP_STARTUP = 2'd0;
  localparam logic [1:0] OP_COMMAND = 2'd1;
  localparam logic [1:0] OP_DATA    = 2'd2;

  localparam logic [1:0] REG_TWO_LINES    = 2'd0;
  localparam logic [1:0] REG_FONT_5X10    = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_US = 2'd2;

  localparam logic [7:0]  TICKS_RESET    = 8'd100;
  localparam logic [12:0] WAIT_NONE_US   = 13'd0;
  localparam logic [12:0] WAIT_SHORT_US  = 13'd38;
  localparam logic [12:0] WAIT_LONG_US   = 13'd2000;
  localparam logic [12:0] WAIT_RESET1_US = 13'd5000;
  localparam logic [12:0] WAIT_RESET2_US = 13'd1000;

  localparam logic [7:0] LCD_FUNCTION_SET  = 8'h20;
  localparam logic [7:0] LCD_DISPLAY_CTRL  = 8'h08;
  localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] LCD_ENTRY_INC     = 8'h06;

  localparam logic [3:0] NIB_RESET = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  localparam logic [3:0] STEP_BYTE_LAST    = 4'd1;
  localparam logic [3:0] STEP_STARTUP_LAST = 4'd11;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       long_wait;
  } in_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [12:0] wait_us;
    logic        last;
  } out_t;

  // classified request, as held in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       long_wait;
  } req_t;

  typedef struct packed {
    logic push;
    req_t req;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    req_t req;
  } q_rd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EMIT,
    B_WAIT
  } back_state_t;

  function automatic out_t strobe_f(input req_t r, input logic [3:0] step,
                                    input logic two_lines, input logic font_5x10);
    out_t       s;
    logic [7:0] fs;
    fs = LCD_FUNCTION_SET | {4'b0000, two_lines, font_5x10, 2'b00};
    s  = '{reg_select: 1'b0, nibble: 4'h0, wait_us: WAIT_NONE_US, last: 1'b0};
    if (r.kind == OP_STARTUP) begin
      case (step)
        4'd0:    begin s.nibble = NIB_RESET; s.wait_us = WAIT_RESET1_US; end
        4'd1:    begin s.nibble = NIB_RESET; s.wait_us = WAIT_RESET2_US; end
        4'd2:    begin s.nibble = NIB_RESET; s.wait_us = WAIT_RESET2_US; end
        4'd3:    begin s.nibble = NIB_4BIT;  s.wait_us = WAIT_SHORT_US;  end
        4'd4:    s.nibble = fs[7:4];
        4'd5:    begin s.nibble = fs[3:0]; s.wait_us = WAIT_SHORT_US; end
        4'd6:    s.nibble = LCD_DISPLAY_CTRL[7:4];
        4'd7:    begin s.nibble = LCD_DISPLAY_CTRL[3:0]; s.wait_us = WAIT_SHORT_US; end
        4'd8:    s.nibble = CMD_CLEAR_DISPLAY[7:4];
        4'd9:    begin s.nibble = CMD_CLEAR_DISPLAY[3:0]; s.wait_us = WAIT_LONG_US; end
        4'd10:   s.nibble = LCD_ENTRY_INC[7:4];
        4'd11:   begin
          s.nibble  = LCD_ENTRY_INC[3:0];
          s.wait_us = WAIT_SHORT_US;
          s.last    = 1'b1;
        end
        default: s.nibble = 4'h0;
      endcase
    end else begin
      s.reg_select = (r.kind == OP_DATA);
      if (step == 4'd0) begin
        s.nibble = r.value[7:4];
      end else begin
        s.nibble  = r.value[3:0];
        s.wait_us = (r.kind == OP_COMMAND && r.long_wait) ? WAIT_LONG_US : WAIT_SHORT_US;
        s.last    = 1'b1;
      end
    end
    return s;
  endfunction

endpackage

// ===== hdl/lcdn_front.sv =====
// Front end: takes request beats, drops the unused op code and classifies the rest.
// Depends on lcdn_pkg; feeds lcdn_fifo.
module lcdn_front import lcdn_pkg::*; (
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  logic  q_full,
  output q_wr_t q_wr
);

  logic known_op;

  always_comb begin
    known_op = (in_data.op == OP_STARTUP) || (in_data.op == OP_COMMAND) ||
               (in_data.op == OP_DATA);
    in_stall = q_full;
    // long wait only applies to commands
    q_wr.req.kind      = in_data.op;
    q_wr.req.value     = (in_data.op == OP_STARTUP) ? 8'h00 : in_data.value;
    q_wr.req.long_wait = (in_data.op == OP_COMMAND) && in_data.long_wait;
    q_wr.push          = in_valid && !q_full && known_op;
  end

endmodule

// ===== hdl/lcdn_fifo.sv =====
// Short request queue between the front end and the strobe sequencer.
// Depends on lcdn_pkg for the request type and depth.
module lcdn_fifo import lcdn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  pop,
  output q_rd_t q_rd
);

  req_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    q_full     = (count == QCNT_W'(QDEPTH));
    q_rd.empty = (count == '0);
    q_rd.req   = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !q_wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(q_wr.push && q_full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && q_rd.empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/lcdn_back.sv =====
// Back end: pops requests and plays out their strobes, timing each wait in microseconds.
// Depends on lcdn_pkg for the strobe table and the state type.
module lcdn_back import lcdn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_rd_t       q_rd,
  output logic        pop,
  input  logic        two_lines,
  input  logic        font_5x10,
  input  logic [7:0]  ticks_per_us,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  back_state_t state;
  back_state_t state_next;
  req_t        req;
  logic [3:0]  step;
  out_t        strobe;
  logic [12:0] us_left;
  logic [7:0]  tick;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_rd.empty) state_next = B_EMIT;
      B_EMIT:  if (!out_stall) state_next = B_WAIT;
      B_WAIT:  if (us_left == '0) state_next = strobe.last ? B_IDLE : B_EMIT;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == B_IDLE) && !q_rd.empty;
    out_valid = (state == B_EMIT);
    out_data  = strobe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        step <= '0;
      end else if (state == B_WAIT && us_left == '0 && !strobe.last) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req    <= q_rd.req;
      strobe <= strobe_f(q_rd.req, 4'd0, two_lines, font_5x10);
    end else if (state == B_EMIT && !out_stall) begin
      // enable pulse of one microsecond, then the wait itself
      us_left <= strobe.wait_us + 13'd1;
      tick    <= '0;
    end else if (state == B_WAIT) begin
      if (us_left != '0) begin
        if (tick == ticks_per_us - 8'd1) begin
          tick    <= '0;
          us_left <= us_left - 13'd1;
        end else begin
          tick <= tick + 8'd1;
        end
      end else if (!strobe.last) begin
        strobe <= strobe_f(req, step + 4'd1, two_lines, font_5x10);
      end
    end
  end

`ifndef ASSERT_OFF
  a_wait_after_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("strobe not followed by a wait");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> (req.kind == OP_STARTUP) ? (step <= STEP_STARTUP_LAST)
                                                 : (step <= STEP_BYTE_LAST))
    else $error("step past end of request");
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |->
      step == ((req.kind == OP_STARTUP) ? STEP_STARTUP_LAST : STEP_BYTE_LAST))
    else $error("last marked on wrong strobe");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped request did not produce a strobe");
`endif

endmodule

// ===== hdl/lcd_nibble_interface_sequencer_unit.sv =====
// Top level of the 4-bit character LCD sequencer: configuration registers, front end,
// request queue and strobe sequencer. Depends on lcdn_pkg, lcdn_front, lcdn_fifo, lcdn_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | in_data  (op, value, long_wait)
//   out      | out_valid / out_stall| out_data (reg_select, nibble, wait_us, last)
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each strobe lasts its wait_us plus one microsecond of enable pulse, timed by the
// microsecond timer in the sequencer, which counts ticks_per_us clocks per microsecond.
// Requests queue two deep ahead of the sequencer.
// Reset is synchronous and clears the queue, the sequencer and the registers.
// An output stall holds the current strobe; its wait starts once the beat is taken.
module lcd_nibble_interface_sequencer_unit import lcdn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       two_lines;
  logic       font_5x10;
  logic [7:0] ticks_per_us;
  q_wr_t      q_wr;
  q_rd_t      q_rd;
  logic       q_full;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_lines    <= 1'b0;
      font_5x10    <= 1'b0;
      ticks_per_us <= TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TWO_LINES:    two_lines    <= cfg_data[0];
        REG_FONT_5X10:    font_5x10    <= cfg_data[0];
        REG_TICKS_PER_US: ticks_per_us <= cfg_data;
        default:          ticks_per_us <= ticks_per_us;
      endcase
    end
  end

  lcdn_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  lcdn_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  lcdn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd         (q_rd),
    .pop          (pop),
    .two_lines    (two_lines),
    .font_5x10    (font_5x10),
    .ticks_per_us (ticks_per_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the 4-bit character LCD sequencer: directed and random requests,
// a strobe predictor and a scoreboard that checks every beat field by field.
// Depends on lcdn_pkg and lcd_nibble_interface_sequencer_unit.
module tb_top;
  import lcdn_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] REG_NONE    = 2'd3;
  localparam int         QUIET_LIMIT = 100000;
  localparam int         PHASES      = 5;
  localparam int         PHASE_ITEMS = 18;

  typedef struct packed {
    logic [1:0] idx;
    logic [7:0] data;
  } reg_wr_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  in_t        in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_ready;

  out_t        strobes_due[$];
  reg_wr_t     pending_writes[$];
  logic        two_lines_q  = 1'b0;
  logic        font_q       = 1'b0;
  logic [7:0]  ticks_q      = TICKS_RESET;
  logic [12:0] tail_wait_us = '0;
  int          faults       = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0;

  lcd_nibble_interface_sequencer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #1 clk = ~clk;

  // receiver back-pressure: stall bursts of random length
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      faults++;
      if (faults <= 10)
        $display("strobe mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_strobes
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (strobes_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected strobe: rs %0d nibble %h wait %0d last %0d",
                     out_data.reg_select, out_data.nibble, out_data.wait_us, out_data.last);
        end else begin
          want = strobes_due.pop_front();
          check_field("reg_select", want.reg_select, out_data.reg_select);
          check_field("nibble", want.nibble, out_data.nibble);
          check_field("wait_us", want.wait_us, out_data.wait_us);
          check_field("last", want.last, out_data.last);
        end
        tail_wait_us = out_data.wait_us;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic void add_strobe(logic rs, logic [3:0] nib, logic [12:0] pause_us,
                                     logic last);
    out_t s;
    s.reg_select = rs;
    s.nibble     = nib;
    s.wait_us    = pause_us;
    s.last       = last;
    strobes_due.push_back(s);
  endfunction

  // high nibble first, no wait between the two halves
  function automatic void add_byte(logic rs, logic [7:0] code, logic [12:0] pause_us,
                                   logic last);
    add_strobe(rs, code[7:4], WAIT_NONE_US, 1'b0);
    add_strobe(rs, code[3:0], pause_us, last);
  endfunction

  function automatic void queue_strobes(in_t req);
    logic [7:0] fn_set;
    fn_set    = LCD_FUNCTION_SET;
    fn_set[3] = two_lines_q;
    fn_set[2] = font_q;
    case (req.op)
      OP_STARTUP: begin
        add_strobe(1'b0, NIB_RESET, WAIT_RESET1_US, 1'b0);
        add_strobe(1'b0, NIB_RESET, WAIT_RESET2_US, 1'b0);
        add_strobe(1'b0, NIB_RESET, WAIT_RESET2_US, 1'b0);
        add_strobe(1'b0, NIB_4BIT, WAIT_SHORT_US, 1'b0);
        add_byte(1'b0, fn_set, WAIT_SHORT_US, 1'b0);
        add_byte(1'b0, LCD_DISPLAY_CTRL, WAIT_SHORT_US, 1'b0);
        add_byte(1'b0, CMD_CLEAR_DISPLAY, WAIT_LONG_US, 1'b0);
        add_byte(1'b0, LCD_ENTRY_INC, WAIT_SHORT_US, 1'b1);
      end
      OP_COMMAND: add_byte(1'b0, req.value, req.long_wait ? WAIT_LONG_US : WAIT_SHORT_US, 1'b1);
      // long_wait has no effect on data
      OP_DATA:    add_byte(1'b1, req.value, WAIT_SHORT_US, 1'b1);
      default:    ;
    endcase
  endfunction

  function automatic in_t make_req(logic [1:0] op, logic [7:0] value, logic long_wait);
    in_t r;
    r.op        = op;
    r.value     = value;
    r.long_wait = long_wait;
    return r;
  endfunction

  // one-bit registers get random upper bits
  function automatic logic [7:0] bit_word(logic b);
    logic [7:0] w;
    w    = 8'($urandom);
    w[0] = b;
    return w;
  endfunction

  function automatic void queue_write(logic [1:0] idx, logic [7:0] data);
    reg_wr_t w;
    w.idx  = idx;
    w.data = data;
    pending_writes.push_back(w);
  endfunction

  // hold cfg_valid across back-to-back writes, drop it after the last beat
  task automatic flush_writes();
    reg_wr_t w;
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      // sample ready at the falling edge ahead of the edge that takes the beat
      @(negedge clk);
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
      case (w.idx)
        REG_TWO_LINES:    two_lines_q = w.data[0];
        REG_FONT_5X10:    font_q      = w.data[0];
        REG_TICKS_PER_US: ticks_q     = w.data;
        default:          ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(in_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // stall only moves at the rising edge; its level at the falling edge is what the edge sees
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    queue_strobes(req);
  endtask

  // drop valid, wait for every strobe, then let the final wait run out
  task automatic drain_block();
    int hold;
    in_valid <= 1'b0;
    while (strobes_due.size() != 0) @(posedge clk);
    hold = (int'(tail_wait_us) + 2) * int'(ticks_q) + 40;
    repeat (hold) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_request(make_req(OP_DATA, 8'hA5, 1'b0));
    send_request(make_req(OP_COMMAND, 8'h5A, 1'b0));
    send_request(make_req(OP_DATA, 8'h3C, 1'b1));
    send_request(make_req(OP_UNUSED, 8'hFF, 1'b1));
    drain_block();
  endtask

  task automatic test_startup_fonts();
    queue_write(REG_TICKS_PER_US, 8'd1);
    for (int k = 0; k < 4; k++) begin
      queue_write(REG_TWO_LINES, bit_word(k[0]));
      queue_write(REG_FONT_5X10, bit_word(k[1]));
      flush_writes();
      send_request(make_req(OP_STARTUP, 8'($urandom), 1'($urandom)));
      drain_block();
    end
  endtask

  task automatic test_byte_extremes();
    send_request(make_req(OP_COMMAND, 8'h00, 1'b0));
    send_request(make_req(OP_COMMAND, 8'hFF, 1'b1));
    send_request(make_req(OP_COMMAND, CMD_CLEAR_DISPLAY, 1'b1));
    send_request(make_req(OP_DATA, 8'h00, 1'b1));
    send_request(make_req(OP_DATA, 8'hFF, 1'b0));
    send_request(make_req(OP_UNUSED, 8'h00, 1'b0));
    send_request(make_req(OP_COMMAND, 8'h80, 1'b0));
    drain_block();
  endtask

  task automatic test_slow_clock();
    queue_write(REG_TICKS_PER_US, 8'hFF);
    flush_writes();
    send_request(make_req(OP_DATA, 8'h12, 1'b0));
    send_request(make_req(OP_DATA, 8'hED, 1'b1));
    send_request(make_req(OP_COMMAND, 8'h0C, 1'b0));
    drain_block();
  endtask

  // a write past the register list must leave every setting alone
  task automatic test_unmapped_register();
    queue_write(REG_TICKS_PER_US, 8'd1);
    queue_write(REG_TWO_LINES, bit_word(1'b1));
    queue_write(REG_FONT_5X10, bit_word(1'b1));
    queue_write(REG_NONE, 8'($urandom));
    flush_writes();
    send_request(make_req(OP_STARTUP, 8'($urandom), 1'($urandom)));
    drain_block();
  endtask

  task automatic test_random_traffic();
    in_t req;
    int  sent;
    int  pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) calm <= 1'b1;
      queue_write(REG_TICKS_PER_US, 8'($urandom_range(1, 4)));
      queue_write(REG_TWO_LINES, bit_word(1'($urandom)));
      queue_write(REG_FONT_5X10, bit_word(1'($urandom)));
      flush_writes();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick          = $urandom_range(0, 99);
        req.value     = 8'($urandom);
        req.long_wait = ($urandom_range(0, 3) == 0);
        if (pick < 8)       req.op = OP_STARTUP;
        else if (pick < 48) req.op = OP_COMMAND;
        else if (pick < 93) req.op = OP_DATA;
        else                req.op = OP_UNUSED;
        send_request(req);
        if (req.op != OP_UNUSED) sent++;
      end
      drain_block();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_startup_fonts();
    test_byte_extremes();
    test_slow_clock();
    test_unmapped_register();
    test_random_traffic();
    if (faults == 0 && strobes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcdn_pkg.sv
hdl/lcdn_front.sv
hdl/lcdn_fifo.sv
hdl/lcdn_back.sv
hdl/lcd_nibble_interface_sequencer_unit.sv
tb/tb_top.sv
